FILE: rtl/cfsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfsc_pkg;

  localparam logic [15:0] FRAME_MAGIC = 16'hE0FD;
  localparam logic [7:0]  CRC_POLY    = 8'h07;
  localparam logic [7:0]  CRC_TOP     = 8'h80;
  localparam logic [7:0]  CRC_INIT    = 8'h00;
  localparam logic [15:0] STATUS_ARMED    = 16'd0;
  localparam logic [15:0] STATUS_DISARMED = 16'd1;
  localparam logic [31:0] THROTTLE_SAFE   = 32'h0000_0000;
  localparam int DATA_LEN  = 32;
  localparam int FRAME_LEN = DATA_LEN + 1;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  typedef struct packed {
    logic        armed;
    logic [31:0] stamp_seconds;
    logic [29:0] stamp_nanoseconds;
    logic [31:0] throttle_word;
    logic [31:0] yaw_word;
    logic [31:0] pitch_word;
    logic [31:0] roll_word;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } beat_t;

  // frame body, byte 0 in the low bits
  typedef logic [8*DATA_LEN-1:0] body_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cfsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfsc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire cfsc_pkg::cmd_t cmd_data,
  output logic                push,
  input  wire logic           queue_full,
  output cfsc_pkg::body_t     body
);
  import cfsc_pkg::*;

  logic [31:0] seq;
  logic [15:0] status;
  logic [31:0] thr;

  assign cmd_ready = !queue_full;
  assign push      = cmd_valid && !queue_full;

  always_comb begin
    status = cmd_data.armed ? STATUS_ARMED : STATUS_DISARMED;
    thr    = cmd_data.armed ? cmd_data.throttle_word : THROTTLE_SAFE;
    body   = {cmd_data.roll_word, cmd_data.pitch_word, cmd_data.yaw_word, thr, seq,
              {2'b00, cmd_data.stamp_nanoseconds}, cmd_data.stamp_seconds,
              status, FRAME_MAGIC};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= 32'd0;
    end else if (push) begin
      seq <= seq + 32'd1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cfsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cfsc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cfsc_pkg::body_t push_body,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output cfsc_pkg::body_t      head
);
  import cfsc_pkg::*;

  body_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_body;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cfsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfsc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            not_empty,
  input  wire cfsc_pkg::body_t head,
  output logic                 pop,
  output logic                 byte_valid,
  input  wire logic            byte_ready,
  output cfsc_pkg::beat_t      byte_data
);
  import cfsc_pkg::*;

  localparam logic [IDX_W-1:0] CRC_IDX = IDX_W'(DATA_LEN);

  body_t            frame;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic [7:0]       crc;
  logic             advance;
  logic             at_crc;
  logic [7:0]       cur_byte;

  assign advance  = !byte_valid || byte_ready;
  assign at_crc   = (idx == CRC_IDX);
  assign cur_byte = at_crc ? crc : frame[7:0];
  // next frame loads while its predecessor's CRC beat goes out
  assign pop      = not_empty && (!busy || (advance && at_crc));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      byte_valid <= 1'b0;
    end else begin
      if (advance) begin
        byte_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && busy && at_crc) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      byte_data.frame_byte <= cur_byte;
      byte_data.last_byte  <= at_crc;
    end
    if (pop) begin
      frame <= head;
      idx   <= '0;
      crc   <= CRC_INIT;
    end else if (advance && busy) begin
      frame <= frame >> 8;
      crc   <= crc8_update(crc, cur_byte);
      idx   <= idx + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/command_frame_serializer_crc8.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake               | payload
// cmd     | in  | cmd_valid / cmd_ready   | cmd_data  (cfsc_pkg::cmd_t), one record per frame
// byte    | out | byte_valid / byte_ready | byte_data (cfsc_pkg::beat_t), one frame byte per beat
//
// Each record gives 33 byte beats (32 body bytes, then the CRC with last_byte set).
// Throughput is set by the one-byte-a-cycle serializer while byte_ready stays high.
// A two-entry frame queue sits between front and serializer; cmd_ready drops only when full.
// The first byte leaves after the record is queued and loaded. Synchronous reset clears the
// sequence counter, the queue and the output; byte_ready low simply holds the beat.

module command_frame_serializer_crc8 (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire cfsc_pkg::cmd_t  cmd_data,
  output logic                 byte_valid,
  input  wire logic            byte_ready,
  output cfsc_pkg::beat_t      byte_data
);
  import cfsc_pkg::*;

  logic  push;
  logic  pop;
  logic  full;
  logic  not_empty;
  body_t body;
  body_t head;

  cfsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .push       (push),
    .queue_full (full),
    .body       (body)
  );

  cfsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_body (body),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  cfsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data)
  );

endmodule

`default_nettype wire

FILE: rtl/cfsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cfsc_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            cmd_valid,
  input wire logic            cmd_ready,
  input wire cfsc_pkg::cmd_t  cmd_data,
  input wire logic            byte_valid,
  input wire logic            byte_ready,
  input wire cfsc_pkg::beat_t byte_data
);
  import cfsc_pkg::*;

  // a stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
    else $error("output beat changed while stalled");

  // a waiting record holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_data))
    else $error("input record changed while waiting");

  a_rst_out: assert property (@(posedge clk) rst |=> !byte_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> cmd_ready)
    else $error("input not ready after reset");

  // frames are 33 beats, so two last beats never follow each other
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && byte_data.last_byte |=> !(byte_valid && byte_data.last_byte))
    else $error("back to back frame ends");

endmodule

bind command_frame_serializer_crc8 cfsc_checker u_cfsc_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd_valid),
  .cmd_ready  (cmd_ready),
  .cmd_data   (cmd_data),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .byte_data  (byte_data)
);

`default_nettype wire
